// ----- sv/dht11_pkg.sv -----
package dht11_pkg;

    // Read sequence phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LOW     = 2'd1,
        PH_HIGH    = 2'd2,
        PH_MEASURE = 2'd3
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_LOW  = 2'd0,
        CFG_START_HIGH = 2'd1,
        CFG_ONE_THRESH = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } cfg_idx_t;

    localparam int FRAME_BITS  = 40;
    localparam int BITS_W      = 6;
    localparam int TIMER_W     = 15;
    localparam int COUNT_W     = 8;
    localparam int CFG_DATA_W  = 15;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam logic [TIMER_W-1:0] START_LOW_RST  = 15'd18000;
    localparam logic [7:0]         START_HIGH_RST = 8'd40;
    localparam logic [7:0]         ONE_THRESH_RST = 8'd40;
    localparam logic [7:0]         TIMEOUT_RST    = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;

    // First bit transition that carries data (after the sensor's response pulses)
    localparam int FIRST_BIT_TRANSITION = 4;

endpackage

// ----- sv/dht11_single_wire_reader.sv -----
// Single-wire humidity/temperature sensor reader.
//
// Input channel (s_*): one item per one-microsecond tick. s_tuser = 1 starts
// a read (the running one, if any, is dropped); s_tuser = 0 is a tick that
// carries the sampled data line level in s_tdata[0].
// Result channel (m_*): exactly one item per input item, describing the state
// after that tick: the drive enable/level to apply to the line, busy, and on
// the tick where a read ends a done flag, the four data bytes and a flag
// that says all 40 bits arrived with a matching additive checksum.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, to be written by the user only
// while idle; the block itself does not enforce this.
// An item accepted at an edge has its result in the output register right
// after that edge. Throughput is one item per cycle while the receiver takes
// results; the output register is the only stage, so the rate is set by that
// register. A stalled receiver holds the result; input is taken again in the
// same cycle the pending result is taken.
// Reset (aresetn low, synchronous) returns to idle with the default timing
// registers and an empty output register.
module dht11_single_wire_reader #(
    parameter int MAX_TRANSITIONS = 85
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [dht11_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dht11_pkg::IN_DATA_W-1:0]  s_tdata,  // [0] line_level, [7:1] zero
    input  logic                            s_tuser,  // [0] action
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] drive_enable, [1] drive_level, [2] done_res, [3] data_good,
    // [11:4] humidity_whole, [19:12] humidity_tenths, [27:20] temp_whole,
    // [35:28] temp_tenths, [36] busy_res, [39:37] zero
    output logic [dht11_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dht11_pkg::*;

    localparam int TRANS_W = $clog2(MAX_TRANSITIONS + 1);
    localparam logic [TRANS_W-1:0] TRANS_MAX = TRANS_W'(MAX_TRANSITIONS);
    localparam logic [TRANS_W-1:0] TRANS_FIRST = TRANS_W'(FIRST_BIT_TRANSITION);
    localparam logic [BITS_W-1:0]  BITS_FULL = BITS_W'(FRAME_BITS);

    // configuration
    logic [TIMER_W-1:0] start_low_reg;
    logic [7:0]         start_high_reg;
    logic [7:0]         one_thresh_reg;
    logic [7:0]         timeout_reg;

    // read state
    phase_t                phase_reg, phase_next;
    logic [TIMER_W-1:0]    timer_reg, timer_next;
    logic [COUNT_W-1:0]    pulse_reg, pulse_next;
    logic                  prev_level_reg, prev_level_next;
    logic [TRANS_W-1:0]    trans_reg, trans_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  finish;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  accept;
    logic                  level;
    logic [TIMER_W-1:0]    timer_inc;
    logic [COUNT_W-1:0]    pulse_inc;
    logic                  take_bit;
    logic [7:0]            byte_sum;
    logic                  good;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign level    = s_tdata[0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign timer_inc = timer_reg + TIMER_W'(1);
    assign pulse_inc = (pulse_reg < COUNT_MAX) ? pulse_reg + COUNT_W'(1) : pulse_reg;
    assign take_bit  = (trans_reg >= TRANS_FIRST) && !trans_reg[0] && (bits_reg < BITS_FULL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_low_reg  <= START_LOW_RST;
            start_high_reg <= START_HIGH_RST;
            one_thresh_reg <= ONE_THRESH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_LOW:  start_low_reg  <= cfg_wdata;
                CFG_START_HIGH: start_high_reg <= cfg_wdata[7:0];
                CFG_ONE_THRESH: one_thresh_reg <= cfg_wdata[7:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // next state for one tick
    always_comb begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        pulse_next      = pulse_reg;
        prev_level_next = prev_level_reg;
        trans_next      = trans_reg;
        bits_next       = bits_reg;
        frame_next      = frame_reg;
        finish          = 1'b0;
        if (s_tuser) begin
            phase_next      = PH_LOW;
            timer_next      = '0;
            pulse_next      = '0;
            prev_level_next = 1'b1;
            trans_next      = '0;
            bits_next       = '0;
            frame_next      = '0;
        end else begin
            unique case (phase_reg)
                PH_LOW: begin
                    timer_next = timer_inc;
                    if (timer_inc >= start_low_reg) begin
                        phase_next = PH_HIGH;
                        timer_next = '0;
                    end
                end
                PH_HIGH: begin
                    timer_next = timer_inc;
                    if (timer_inc >= TIMER_W'(start_high_reg)) begin
                        phase_next      = PH_MEASURE;
                        timer_next      = '0;
                        pulse_next      = '0;
                        prev_level_next = 1'b1;
                        trans_next      = '0;
                    end
                end
                PH_MEASURE: begin
                    if (level == prev_level_reg) begin
                        pulse_next = pulse_inc;
                        finish     = (pulse_inc >= timeout_reg);
                    end else begin
                        prev_level_next = level;
                        if (take_bit) begin
                            frame_next = {frame_reg[FRAME_BITS-2:0],
                                          (pulse_reg > one_thresh_reg)};
                            bits_next  = bits_reg + BITS_W'(1);
                        end
                        trans_next = trans_reg + TRANS_W'(1);
                        pulse_next = '0;
                        finish     = (trans_next >= TRANS_MAX);
                    end
                    if (finish) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end
    end

    // result fields; byte 0 is the top byte of the frame
    assign byte_sum = frame_next[39:32] + frame_next[31:24]
                    + frame_next[23:16] + frame_next[15:8];
    assign good     = (bits_next >= BITS_FULL) && (byte_sum == frame_next[7:0]);

    always_comb begin
        out_data_next        = '0;
        out_data_next[0]     = (phase_next == PH_LOW) || (phase_next == PH_HIGH);
        out_data_next[1]     = (phase_next == PH_HIGH);
        out_data_next[36]    = (phase_next != PH_IDLE);
        if (finish) begin
            out_data_next[2]     = 1'b1;
            out_data_next[3]     = good;
            out_data_next[11:4]  = frame_next[39:32];
            out_data_next[19:12] = frame_next[31:24];
            out_data_next[27:20] = frame_next[23:16];
            out_data_next[35:28] = frame_next[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            pulse_reg      <= '0;
            prev_level_reg <= 1'b1;
            trans_reg      <= '0;
            bits_reg       <= '0;
            frame_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                pulse_reg      <= pulse_next;
                prev_level_reg <= prev_level_next;
                trans_reg      <= trans_next;
                bits_reg       <= bits_next;
                frame_reg      <= frame_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    // a start always yields a busy, low-driving result
    a_start_drives_low: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser |=> m_tvalid && m_tdata[0] && !m_tdata[1] && m_tdata[36])
        else $error("start did not drive the line low");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[36] && !m_tdata[0])
        else $error("finished read still busy");

    a_good_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("data_good without done");

    a_bits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_FULL)
        else $error("bit count past frame length");

    a_trans_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MEASURE |-> trans_reg < TRANS_MAX)
        else $error("measuring past the transition limit");

endmodule

// ----- bench/dht11_result_checker.sv -----
module dht11_result_checker
    import dht11_pkg::*;
#(
    parameter int EDGE_LIMIT = 85
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending_count,
    output logic                  reader_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    // Field order matches m_tdata[36:0], lowest bit last.
    typedef struct packed {
        logic       busy;
        logic [7:0] temp_tenths;
        logic [7:0] temp_whole;
        logic [7:0] hum_tenths;
        logic [7:0] hum_whole;
        logic       data_good;
        logic       done;
        logic       drive_level;
        logic       drive_enable;
    } reading_t;

    // register copies
    logic [TIMER_W-1:0] low_ticks;
    logic [7:0]         high_ticks;
    logic [7:0]         one_thresh;
    logic [7:0]         abort_ticks;

    // sequencer copy
    phase_t             seq_phase;
    logic [TIMER_W-1:0] tick_timer;
    logic [COUNT_W-1:0] pulse_len;
    logic               last_level;
    logic [6:0]         edge_idx;
    logic [BITS_W-1:0]  bit_count;
    logic [39:0]        frame_bits;

    reading_t expected_readings[$];
    reading_t want;
    reading_t got;

    initial fail_count = 0;

    task automatic close_frame(inout reading_t r);
        logic [7:0] sum;
        sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16] + frame_bits[15:8];
        r.done        = 1'b1;
        r.data_good   = (bit_count >= FRAME_BITS) && (sum == frame_bits[7:0]);
        r.hum_whole   = frame_bits[39:32];
        r.hum_tenths  = frame_bits[31:24];
        r.temp_whole  = frame_bits[23:16];
        r.temp_tenths = frame_bits[15:8];
        seq_phase     = PH_IDLE;
    endtask

    task automatic advance_reader(input logic start, input logic level, output reading_t r);
        r = '0;
        if (start) begin
            seq_phase  = PH_LOW;
            tick_timer = '0;
            pulse_len  = '0;
            last_level = 1'b1;
            edge_idx   = '0;
            bit_count  = '0;
            frame_bits = '0;
        end else begin
            case (seq_phase)
                PH_LOW: begin
                    tick_timer = tick_timer + 1'b1;
                    if (tick_timer >= low_ticks) begin
                        seq_phase  = PH_HIGH;
                        tick_timer = '0;
                    end
                end
                PH_HIGH: begin
                    tick_timer = tick_timer + 1'b1;
                    if (tick_timer >= high_ticks) begin
                        seq_phase  = PH_MEASURE;
                        tick_timer = '0;
                        pulse_len  = '0;
                        last_level = 1'b1;
                        edge_idx   = '0;
                    end
                end
                PH_MEASURE: begin
                    if (level == last_level) begin
                        if (pulse_len != COUNT_MAX)
                            pulse_len = pulse_len + 1'b1;
                        if (pulse_len >= abort_ticks)
                            close_frame(r);
                    end else begin
                        last_level = level;
                        // even edges from the first data edge on carry a bit
                        if (edge_idx >= FIRST_BIT_TRANSITION && !edge_idx[0] &&
                            bit_count < FRAME_BITS) begin
                            frame_bits = {frame_bits[38:0], pulse_len > one_thresh};
                            bit_count  = bit_count + 1'b1;
                        end
                        edge_idx  = edge_idx + 1'b1;
                        pulse_len = '0;
                        if (edge_idx >= EDGE_LIMIT)
                            close_frame(r);
                    end
                end
                default: ;
            endcase
        end
        r.drive_enable = (seq_phase == PH_LOW) || (seq_phase == PH_HIGH);
        r.drive_level  = (seq_phase == PH_HIGH);
        r.busy         = (seq_phase != PH_IDLE);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            low_ticks   = START_LOW_RST;
            high_ticks  = START_HIGH_RST;
            one_thresh  = ONE_THRESH_RST;
            abort_ticks = TIMEOUT_RST;
            seq_phase   = PH_IDLE;
            tick_timer  = '0;
            pulse_len   = '0;
            last_level  = 1'b1;
            edge_idx    = '0;
            bit_count   = '0;
            frame_bits  = '0;
            expected_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("result item with no expectation pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    got  = reading_t'(m_tdata[36:0]);
                    check_field("drive_enable", want.drive_enable, got.drive_enable);
                    check_field("drive_level", want.drive_level, got.drive_level);
                    check_field("done_res", want.done, got.done);
                    check_field("data_good", want.data_good, got.data_good);
                    check_field("humidity_whole", want.hum_whole, got.hum_whole);
                    check_field("humidity_tenths", want.hum_tenths, got.hum_tenths);
                    check_field("temp_whole", want.temp_whole, got.temp_whole);
                    check_field("temp_tenths", want.temp_tenths, got.temp_tenths);
                    check_field("busy_res", want.busy, got.busy);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_START_LOW:  low_ticks   = cfg_wdata[TIMER_W-1:0];
                    CFG_START_HIGH: high_ticks  = cfg_wdata[7:0];
                    CFG_ONE_THRESH: one_thresh  = cfg_wdata[7:0];
                    CFG_TIMEOUT:    abort_ticks = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_reader(s_tuser, s_tdata[0], want);
                expected_readings.push_back(want);
            end
        end
        pending_count <= expected_readings.size();
        reader_busy   <= (seq_phase != PH_IDLE);
    end

endmodule

// ----- bench/dht11_single_wire_reader_tb.sv -----
module dht11_single_wire_reader_tb;
    import dht11_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Must match the block's transition limit; the checker gets the same value.
    localparam int MAX_EDGES = 85;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [0] line_level, [7:1] zero
    logic                  s_tuser;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] drive_enable, [1] drive_level, [2] done_res, [3] data_good,
    // [11:4] humidity_whole, [19:12] humidity_tenths, [27:20] temp_whole,
    // [35:28] temp_tenths, [36] busy_res, [39:37] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    logic reader_busy;

    // Stimulus-side copy of the timing registers, used only to size the
    // generated line waveforms (the checker keeps its own copy).
    int cfg_low  = START_LOW_RST;
    int cfg_high = START_HIGH_RST;
    int cfg_thr  = ONE_THRESH_RST;
    int cfg_tmo  = TIMEOUT_RST;

    int short_max = 4;  // upper bound of non-data segment lengths, in ticks
    int sent_items = 0;
    bit no_idle = 1'b0; // 1 = neither side inserts gaps or stalls

    dht11_single_wire_reader #(
        .MAX_TRANSITIONS(MAX_EDGES)
    ) u_top (
        .aclk, .aresetn,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    dht11_result_checker #(
        .EDGE_LIMIT(MAX_EDGES)
    ) u_checker (
        .aclk, .aresetn,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .pending_count, .reader_busy
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Receiver: stalls about 15% of cycles unless a no-idle stretch is on.
    always @(posedge aclk)
        m_tready <= no_idle || ($urandom_range(99) >= 15);

    // Safety net against a hung handshake.
    initial begin
        #400_000;
        $display("TB_ERROR");
        $finish;
    end

    // One item on the input channel. Random gaps go in front of the item so
    // that valid is never dropped and raised in the same step. s_tready is
    // sampled right after the edge, i.e. its pre-edge value.
    task automatic send_item(input logic act, input logic lvl);
        if (!no_idle) begin
            while ($urandom_range(99) < 15) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, lvl};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic hold_line(input logic lvl, input int n);
        repeat (n) send_item(1'b0, lvl);
    endtask

    // Four data bytes plus the additive checksum; optionally a bad checksum.
    function automatic logic [39:0] make_payload(input bit corrupt);
        logic [7:0] b0, b1, b2, b3, cs;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        cs = b0 + b1 + b2 + b3;
        if (corrupt)
            cs = cs ^ 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, cs};
    endfunction

    // Full read as the sensor would answer it: start, the driven low/high
    // window (line samples there are junk and must be ignored), a short
    // pull-up stretch, then n_edges line transitions. Edge k leaves the line
    // at level k%2. Odd edges from 3 on open the high half of a data bit whose
    // length encodes the payload bit, MSB first. With tail set and fewer than
    // MAX_EDGES transitions, the last level is held until the block times out.
    // loose ignores the timeout cap, so pulses may abort the read early.
    task automatic sensor_read(input logic [39:0] payload, input int n_edges,
                               input bit loose, input bit tail);
        int cap;
        int len;
        int slot;
        cap = (cfg_tmo < 1) ? 1 : cfg_tmo;
        send_item(1'b1, 1'($urandom_range(1)));
        repeat (((cfg_low < 1) ? 1 : cfg_low) + ((cfg_high < 1) ? 1 : cfg_high))
            send_item(1'b0, 1'($urandom_range(1)));
        // pulse count climbs from zero here, so stay below the timeout
        hold_line(1'b1, $urandom_range(0, (cap - 1 < 3) ? cap - 1 : 3));
        for (int k = 0; k < n_edges; k++) begin
            slot = (k - 3) / 2;
            if (k >= 3 && k % 2 == 1 && slot < FRAME_BITS)
                len = payload[39 - slot] ? cfg_thr + 2 + $urandom_range(0, 2)
                                         : $urandom_range(1, cfg_thr + 1);
            else
                len = $urandom_range(1, short_max);
            if (loose)
                len = $urandom_range(1, cap + 3);
            else if (len > cap)
                len = cap;
            if (k == n_edges - 1) begin
                if (n_edges >= MAX_EDGES)
                    len = 1;          // read ends on this edge
                else if (tail)
                    len = cap + 1;    // let it time out
            end
            hold_line(1'(k % 2), len);
        end
        if (n_edges == 0 && tail)
            hold_line(1'b1, cap);
    endtask

    // One read of a randomly chosen kind; mostly well-formed frames.
    task automatic random_read();
        int pick;
        logic [39:0] payload;
        pick    = $urandom_range(99);
        payload = make_payload($urandom_range(99) < 15);
        if (pick < 60) begin
            // full frame, ending on timeout (83 or 84 line transitions) or on the transition limit
            sensor_read(payload, 83 + $urandom_range(0, 2), 1'b0, 1'b1);
        end else if (pick < 72) begin
            // short frame
            sensor_read(payload, $urandom_range(0, 82), 1'b0, 1'b1);
        end else if (pick < 82) begin
            // start while busy: abandon a partial read mid-measure
            sensor_read(payload, $urandom_range(0, 60), 1'b0, 1'b0);
            sensor_read(make_payload(1'b0), 83 + $urandom_range(0, 2), 1'b0, 1'b1);
        end else if (pick < 90) begin
            // noisy line, pulses may overrun the timeout
            sensor_read(payload, $urandom_range(20, MAX_EDGES), 1'b1, 1'b1);
        end else begin
            // ticks while idle, then a frame that runs into the edge limit
            repeat ($urandom_range(1, 4))
                send_item(1'b0, 1'($urandom_range(1)));
            sensor_read(payload, MAX_EDGES, 1'b0, 1'b1);
        end
    endtask

    // Drop valid, let every expected result come out, and if a read is
    // still running, feed a steady line until it times out.
    task automatic settle_reader();
        bit idle_now;
        idle_now = 1'b0;
        while (!idle_now) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_count != 0);
            if (reader_busy)
                hold_line(1'b1, 16);
            else
                idle_now = 1'b1;
        end
    endtask

    // All four registers in back-to-back cycles; enable drops after the last.
    task automatic apply_config(input int low, input int high, input int thr, input int tmo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_START_LOW;
        cfg_wdata <= CFG_DATA_W'(low);
        @(posedge aclk);
        cfg_index <= CFG_START_HIGH;
        cfg_wdata <= CFG_DATA_W'(high);
        @(posedge aclk);
        cfg_index <= CFG_ONE_THRESH;
        cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= CFG_DATA_W'(tmo);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_low  = low;
        cfg_high = high;
        cfg_thr  = thr;
        cfg_tmo  = tmo;
    endtask

    task automatic run_phase(input int low, input int high, input int thr, input int tmo,
                             input int seg_max, input int reads);
        settle_reader();
        apply_config(low, high, thr, tmo);
        short_max = seg_max;
        repeat (reads) random_read();
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_START_LOW;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // ticks while idle are ignored
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        // short timings; start, a few ticks in the low window, then a
        // restart while busy that runs a full frame ending on timeout
        run_phase(2, 1, 2, 8, 4, 0);
        send_item(1'b1, 1'b0);
        hold_line(1'b0, 2);
        sensor_read(make_payload(1'b0), 83, 1'b0, 1'b1);

        // --- register sweeps ---
        // long stretch with no gaps or stalls on either side
        no_idle = 1'b1;
        run_phase(1, 1, 1, 6, 3, 2);
        settle_reader();
        no_idle = 1'b0;
        // zero timing registers behave like one
        run_phase(0, 0, 1, 0, 2, 2);
        // smallest nonzero timeout
        run_phase(1, 1, 1, 1, 1, 2);

        // --- random registers, short timings ---
        while (sent_items < 1350)
            run_phase($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 5),
                      $urandom_range(6, 20), $urandom_range(2, 5), 1);

        // drain, then let the pipeline run on before the final check
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
